### hdl/kcqt_pkg.sv
// ----------------------------------------------------------------------------
// kcqt_pkg
// Shared types and constants of the keyed call quota table: sequencer
// states, result status codes and count limits.
// ----------------------------------------------------------------------------
`default_nettype none

package kcqt_pkg;

    // Widths of the fixed fields of one item
    localparam int COUNT_BITS = 31;
    localparam int LIMIT_BITS = 32;
    localparam int STAT_BITS  = 2;

    // Count saturates here
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Result status codes
    typedef logic [STAT_BITS-1:0] t_status;
    localparam t_status STAT_HIT   = 2'd0;
    localparam t_status STAT_NEW   = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;
    localparam t_status STAT_EMPTY = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage : kcqt_pkg

`default_nettype wire

### hdl/kcqt_ram.sv
// ----------------------------------------------------------------------------
// kcqt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kcqt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : kcqt_ram

`default_nettype wire

### hdl/keyed_call_quota_table.sv
// ----------------------------------------------------------------------------
// keyed_call_quota_table
// Per-key call counter with a limit: looks up a key in a slot table, claims
// a free slot on a miss, counts the call and decides whether to abort it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one call: i_key and
//   i_call_limit. Output channel (o_out_valid / i_out_ready) returns one
//   result per call: o_abort, o_status, o_limit_mismatch, o_call_count.
//   Slots are claimed in ascending order and never released, so the used
//   slots are always 0 .. fill-1 and a fill counter stands for the used bits.
//   A lookup reads one slot per cycle from the slot RAM and compares its key
//   with one shared comparator. A miss scans every used slot before the
//   result is loaded; a hit on slot j ends the scan early, and an empty key
//   or an empty table skips the scan. The block accepts no item while one is
//   in work; it is ready for the next item in the cycle after the result is
//   loaded. A finished result sits in the output register while the next
//   item is accepted; when the receiver stalls, the result waits there and
//   the next item holds in its final step.
//   Reset clears the fill counter (empty table) and all control state; the
//   slot RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_call_quota_table #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Call input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_call_limit,
    // Result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_abort,
    output logic [1:0]       o_status,
    output logic             o_limit_mismatch,
    output logic [30:0]      o_call_count
);

    localparam int CB    = kcqt_pkg::COUNT_BITS;
    localparam int LB    = kcqt_pkg::LIMIT_BITS;
    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW    = $clog2(ENTRIES + 1);
    localparam int WIDTH = KEY_BITS + CB + LB;
    localparam logic [FW-1:0] FILL_FULL = FW'(ENTRIES);

    // Sequencer and item registers
    kcqt_pkg::t_state  r_state, n_state;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_addr;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;
    logic [KEY_BITS-1:0] r_key;
    logic [LB-1:0]     r_lim;
    kcqt_pkg::t_status r_stat;
    logic [AW-1:0]     r_slot;
    logic [CB-1:0]     r_cnt;
    logic [LB-1:0]     r_slim;
    logic              r_mism;

    // Output register
    logic              r_out_vld;
    logic              r_abort;
    kcqt_pkg::t_status r_out_stat;
    logic              r_out_mism;
    logic [CB-1:0]     r_out_cnt;

    // RAM ports and decode
    logic              ram_we;
    logic              ram_re;
    logic [WIDTH-1:0]  ram_wdata;
    logic [WIDTH-1:0]  ram_rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [CB-1:0]     rd_cnt;
    logic [LB-1:0]     rd_lim;

    logic              accept;
    logic              key_zero;
    logic              issue;
    logic              hit;
    logic              scan_end;
    logic              out_free;
    logic              finish;
    logic              uses_slot;
    logic [CB-1:0]     new_cnt;
    logic              cnt_over;

    kcqt_ram #(
        .WIDTH (WIDTH),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign {rd_key, rd_cnt, rd_lim} = ram_rdata;

    // Shared compare unit and scan bookkeeping
    assign accept    = i_in_valid && o_in_ready;
    assign key_zero  = (i_key[KEY_BITS-1:0] == '0);
    assign issue     = (r_addr < r_fill);
    assign hit       = r_rd_vld && (rd_key == r_key);
    assign scan_end  = !issue && !r_rd_vld;
    assign out_free  = !r_out_vld || i_out_ready;
    assign uses_slot = (r_stat == kcqt_pkg::STAT_HIT) || (r_stat == kcqt_pkg::STAT_NEW);

    // Count update and abort decision
    assign new_cnt  = (r_cnt == kcqt_pkg::COUNT_MAX) ? r_cnt : r_cnt + CB'(1);
    assign cnt_over = ($signed({1'b0, new_cnt}) > $signed(r_slim));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kcqt_pkg::S_IDLE: begin
                if (accept) begin
                    if (key_zero || (r_fill == '0)) begin
                        n_state = kcqt_pkg::S_FINISH;
                    end else begin
                        n_state = kcqt_pkg::S_SCAN;
                    end
                end
            end
            kcqt_pkg::S_SCAN: begin
                if (hit || scan_end) begin
                    n_state = kcqt_pkg::S_FINISH;
                end
            end
            kcqt_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = kcqt_pkg::S_IDLE;
                end
            end
            default: n_state = kcqt_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            kcqt_pkg::S_IDLE:   o_in_ready = 1'b1;
            kcqt_pkg::S_SCAN:   ram_re     = issue && !hit;
            kcqt_pkg::S_FINISH: finish     = out_free;
            default: ;
        endcase
    end

    assign ram_we    = finish && uses_slot;
    assign ram_wdata = {r_key, new_cnt, r_slim};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kcqt_pkg::S_IDLE;
            r_fill    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= ram_re;
            if (finish && (r_stat == kcqt_pkg::STAT_NEW)) begin
                r_fill <= r_fill + FW'(1);
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Item datapath: latch the call, advance the scan, record the slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= i_key[KEY_BITS-1:0];
            r_lim  <= i_call_limit;
            r_addr <= '0;
            r_slot <= '0;
            r_cnt  <= '0;
            r_slim <= i_call_limit;
            r_mism <= 1'b0;
            r_stat <= key_zero ? kcqt_pkg::STAT_EMPTY : kcqt_pkg::STAT_NEW;
        end else if (r_state == kcqt_pkg::S_SCAN) begin
            if (ram_re) begin
                r_addr    <= r_addr + FW'(1);
                r_rd_addr <= r_addr[AW-1:0];
            end
            if (hit) begin
                r_stat <= kcqt_pkg::STAT_HIT;
                r_slot <= r_rd_addr;
                r_cnt  <= rd_cnt;
                r_slim <= rd_lim;
                r_mism <= (rd_lim != r_lim);
            end else if (scan_end) begin
                if (r_fill == FILL_FULL) begin
                    r_stat <= kcqt_pkg::STAT_FULL;
                end else begin
                    r_stat <= kcqt_pkg::STAT_NEW;
                    r_slot <= r_fill[AW-1:0];
                end
            end
        end
    end

    // Load the output register when the item finishes
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_stat <= r_stat;
            if (uses_slot) begin
                r_abort    <= cnt_over;
                r_out_mism <= r_mism;
                r_out_cnt  <= new_cnt;
            end else begin
                r_abort    <= (r_stat == kcqt_pkg::STAT_EMPTY);
                r_out_mism <= 1'b0;
                r_out_cnt  <= '0;
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_abort          = r_abort;
    assign o_status         = r_out_stat;
    assign o_limit_mismatch = r_out_mism;
    assign o_call_count     = r_out_cnt;

endmodule : keyed_call_quota_table

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of keyed_call_quota_table. It drives call items through the
// valid/ready input channel. A table model in the bench predicts each
// result: lookup, slot claim, count, abort decision and limit mismatch.
// A checker compares every result field by field with the oldest
// prediction. The run covers empty keys, extreme keys and limits,
// mismatching limits, a hot set of repeating keys, a table fill and a
// long phase on the full table. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 64;
    localparam int CYCLE_MAX  = 400000;
    localparam int HOT_KEYS   = 12;
    localparam int MAX_REPORT = 10;

    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

    // One predicted or observed result
    typedef struct packed {
        logic                            abort;
        kcqt_pkg::t_status               status;
        logic                            mismatch;
        logic [kcqt_pkg::COUNT_BITS-1:0] count;
    } t_call_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [63:0] i_key;
    logic [31:0] i_call_limit;
    logic o_out_valid;
    logic i_out_ready;
    logic o_abort;
    logic [1:0] o_status;
    logic o_limit_mismatch;
    logic [30:0] o_call_count;

    keyed_call_quota_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_key            (i_key),
        .i_call_limit     (i_call_limit),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_abort          (o_abort),
        .o_status         (o_status),
        .o_limit_mismatch (o_limit_mismatch),
        .o_call_count     (o_call_count)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Model of the slot table
    logic                            tbl_used  [ENTRIES];
    logic [63:0]                     tbl_key   [ENTRIES];
    logic [kcqt_pkg::COUNT_BITS-1:0] tbl_count [ENTRIES];
    logic signed [31:0]              tbl_limit [ENTRIES];
    int                              tbl_fill;

    t_call_result quota_results_due[$];

    int  err_cnt;
    int  cycle_cnt;
    int  items_sent;
    int  n_hit, n_new, n_full, n_empty, n_abort, n_mismatch;
    bit  calm;
    int  stall_left;

    logic [63:0]        hot_key [HOT_KEYS];
    logic signed [31:0] hot_lim [HOT_KEYS];

    // Look up one call in the table model, update it and return the result
    function automatic t_call_result count_call(input logic [63:0] key_in,
                                                input logic [31:0] lim_in);
        logic [63:0]        key;
        logic signed [31:0] lim;
        int                 hit;
        int                 free_slot;
        int                 s;
        t_call_result       r;
        key       = key_in & KEY_MASK;
        lim       = lim_in;
        hit       = -1;
        free_slot = -1;
        r         = '0;
        if (key == 64'd0) begin
            r.abort  = 1'b1;
            r.status = kcqt_pkg::STAT_EMPTY;
            return r;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_used[i]) begin
                if (hit < 0 && tbl_key[i] == key) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit >= 0) begin
            s        = hit;
            r.status = kcqt_pkg::STAT_HIT;
            r.mismatch = (tbl_limit[s] != lim);
        end else if (free_slot >= 0) begin
            s            = free_slot;
            r.status     = kcqt_pkg::STAT_NEW;
            tbl_used[s]  = 1'b1;
            tbl_key[s]   = key;
            tbl_count[s] = '0;
            tbl_limit[s] = lim;
            tbl_fill++;
        end else begin
            r.status = kcqt_pkg::STAT_FULL;
            return r;
        end
        // Saturate the count at its maximum
        if (tbl_count[s] != kcqt_pkg::COUNT_MAX) tbl_count[s] = tbl_count[s] + 1'b1;
        r.count = tbl_count[s];
        r.abort = (int'({1'b0, tbl_count[s]}) > int'(tbl_limit[s]));
        return r;
    endfunction

    // Random nonzero key over all 64 bits
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        if ((k & KEY_MASK) == 64'd0) k = 64'd1;
        return k;
    endfunction

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORT) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Send one call item; entered and left at a falling edge
    task automatic send_call(input logic [63:0] key, input logic [31:0] lim);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_key        <= key;
        i_call_limit <= lim;
        do @(posedge i_clk); while (!o_in_ready);
        quota_results_due.push_back(count_call(key, lim));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Receiver side: stall in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_call_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (quota_results_due.size() == 0) begin
                report_error("result with no call waiting");
            end else begin
                e = quota_results_due.pop_front();
                if (o_abort !== e.abort || o_status !== e.status ||
                    o_limit_mismatch !== e.mismatch || o_call_count !== e.count) begin
                    report_error($sformatf(
                        "exp abort=%0d status=%0d mismatch=%0d count=%0d, got %0d %0d %0d %0d",
                        e.abort, e.status, e.mismatch, e.count,
                        o_abort, o_status, o_limit_mismatch, o_call_count));
                end
                case (e.status)
                    kcqt_pkg::STAT_HIT:  n_hit++;
                    kcqt_pkg::STAT_NEW:  n_new++;
                    kcqt_pkg::STAT_FULL: n_full++;
                    default:             n_empty++;
                endcase
                if (e.abort) n_abort++;
                if (e.mismatch) n_mismatch++;
            end
        end
    end

    // Watchdog on the cycle count
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Empty keys abort at once and leave the table alone
    task automatic test_empty_key();
        send_call(64'd0, 32'd0);
        send_call(64'd0, 32'hFFFF_FFFF);
        send_call(64'd0, 32'h7FFF_FFFF);
    endtask

    // Claims with extreme keys and limits
    task automatic test_claim_extremes();
        send_call({64{1'b1}}, 32'h7FFF_FFFF);
        send_call({64{1'b1}}, 32'h7FFF_FFFF);
        // Negative limit: any count aborts
        send_call(64'd1, 32'h8000_0000);
        send_call(64'd1, 32'h8000_0000);
        send_call(64'h8000_0000_0000_0000, 32'd0);
        send_call(64'h5555_5555_5555_5555, 32'h5555_5555);
        send_call(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    endtask

    // Count crossing the limit and limit mismatches keeping the old limit
    task automatic test_limit_rules();
        send_call(64'd2, 32'd2);
        send_call(64'd2, 32'd2);
        send_call(64'd2, 32'd2);
        send_call(64'd2, 32'd5);
        send_call(64'd3, 32'd1);
        send_call(64'd3, 32'd0);
        send_call({64{1'b1}}, 32'hFFFF_FFFF);
    endtask

    // Hot set of repeating keys with small limits, some noise
    task automatic test_hot_keys(input int n);
        int r;
        int h;
        for (int i = 0; i < HOT_KEYS; i++) begin
            hot_key[i] = fresh_key();
            hot_lim[i] = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8);
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            h = $urandom_range(0, HOT_KEYS - 1);
            if (r < 60)      send_call(hot_key[h], hot_lim[h]);
            else if (r < 72) send_call(hot_key[h], $urandom);
            else if (r < 85) send_call(64'd0, $urandom);
            else if (r < 95) send_call(hot_key[h], $urandom_range(0, 8));
            else             send_call(fresh_key(), $urandom);
        end
    endtask

    // Claim fresh keys until no slot is free, then overflow a little
    task automatic test_fill_table();
        while (tbl_fill < ENTRIES) send_call(fresh_key(), $urandom_range(0, 20));
        repeat (3) send_call(fresh_key(), $urandom);
    endtask

    // Hits, misses and empty keys on the full table; calm at the end
    task automatic test_full_table(input int n);
        int r;
        int idx;
        for (int i = 0; i < n; i++) begin
            if (i == n - 100) calm = 1'b1;
            r   = $urandom_range(0, 99);
            idx = $urandom_range(0, tbl_fill - 1);
            if (r < 40)      send_call(tbl_key[idx], tbl_limit[idx]);
            else if (r < 50) send_call(tbl_key[idx], $urandom);
            else if (r < 75) send_call(fresh_key(), $urandom);
            else if (r < 85) send_call(64'd0, $urandom);
            else             send_call(hot_key[idx % HOT_KEYS], hot_lim[idx % HOT_KEYS]);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_key        = '0;
        i_call_limit = '0;
        i_out_ready  = 1'b0;
        stall_left   = 0;
        calm         = 1'b0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        items_sent   = 0;
        tbl_fill     = 0;
        n_hit = 0; n_new = 0; n_full = 0; n_empty = 0; n_abort = 0; n_mismatch = 0;
        for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_key();
        test_claim_extremes();
        test_limit_rules();
        test_hot_keys(300);
        test_fill_table();
        test_full_table(250);
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then let the block settle
        while (quota_results_due.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("Sent %0d calls: %0d hits, %0d claims, %0d on full table, %0d empty keys",
                 items_sent, n_hit, n_new, n_full, n_empty);
        $display("Aborts %0d, limit mismatches %0d, errors %0d",
                 n_abort, n_mismatch, err_cnt);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule : tb

`default_nettype wire
